// ===== sv/its_pkg.sv =====
package its_pkg;

	localparam int TASK_SLOTS = 32;
	localparam int TIME_BITS = 32;

	localparam int FIELD_BITS = 32;
	localparam int IN_TDATA_W = 104;
	localparam int OUT_TDATA_W = 8;
	localparam int INDEX_W = 5;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_REG   = 2'd1,
		KIND_TICK  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_REGISTERED = 2'd0,
		ST_FULL       = 2'd1,
		ST_FIRED      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_REG,
		S_WALK,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic idle;
		logic clear;
		logic reg_do;
		logic walk_start;
		logic walk_en;
		logic flush;
	} ctrl_cmd_t;

	typedef struct packed {
		logic  in_fire;
		kind_t in_kind;
		logic  out_free;
		logic  walk_done;
		logic  pend_valid;
	} dp_stat_t;

endpackage

// ===== sv/interval_task_scheduler.sv =====
// Periodic task table. A register item is taken and then waits for room at the result port. A
// tick item walks the registered slots one per cycle, set by the single read port of the task
// tables; a stalled result port holds the walk. A fired task is reported once the walk knows whether
// another task fires after it, so that the final result of a tick carries tlast. A clear item
// is done in the idle state, and the block stays ready for the next item.
module interval_task_scheduler #(
	parameter int TASK_SLOTS = its_pkg::TASK_SLOTS,
	parameter int TIME_BITS = its_pkg::TIME_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// current time, interval, debounce time, dispatch flag, zero fill
	input  logic [its_pkg::IN_TDATA_W-1:0]   s_tdata,
	// kind
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// task_index, run_dispatch, zero fill
	output logic [its_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// status
	output logic [1:0]                       m_tuser,
	output logic                             m_tlast
);

	its_pkg::ctrl_cmd_t cmd;
	its_pkg::dp_stat_t  stat;

	its_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	its_dpath #(
		.TASK_SLOTS (TASK_SLOTS),
		.TIME_BITS  (TIME_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.stat     (stat)
	);

	a_reg_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reg_do |-> stat.out_free)
		else $error("register result issued while the output register is busy");

	a_flush_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> (stat.out_free && stat.pend_valid))
		else $error("flush issued without a pending fired task or room");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !stat.pend_valid)
		else $error("fired task still pending while taking a new item");

endmodule

// ===== sv/its_ram.sv =====
module its_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/its_ctrl.sv =====
module its_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  its_pkg::dp_stat_t     stat,
	output its_pkg::ctrl_cmd_t    cmd
);

	its_pkg::state_t state_q;
	its_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= its_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			its_pkg::S_IDLE: begin
				cmd.idle = 1'b1;
				if (stat.in_fire) begin
					case (stat.in_kind)
						its_pkg::KIND_CLEAR: begin
							cmd.clear = 1'b1;
						end
						its_pkg::KIND_REG: begin
							state_d = its_pkg::S_REG;
						end
						its_pkg::KIND_TICK: begin
							cmd.walk_start = 1'b1;
							state_d = its_pkg::S_WALK;
						end
						default: begin
							state_d = its_pkg::S_IDLE;
						end
					endcase
				end
			end
			its_pkg::S_REG: begin
				if (stat.out_free) begin
					cmd.reg_do = 1'b1;
					state_d = its_pkg::S_IDLE;
				end
			end
			its_pkg::S_WALK: begin
				cmd.walk_en = 1'b1;
				if (stat.walk_done) begin
					state_d = its_pkg::S_FLUSH;
				end
			end
			its_pkg::S_FLUSH: begin
				if (!stat.pend_valid) begin
					state_d = its_pkg::S_IDLE;
				end else if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d = its_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = its_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/its_dpath.sv =====
module its_dpath #(
	parameter int TASK_SLOTS = its_pkg::TASK_SLOTS,
	parameter int TIME_BITS = its_pkg::TIME_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [its_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [its_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic [1:0]                       m_tuser,
	output logic                             m_tlast,
	input  its_pkg::ctrl_cmd_t               cmd,
	output its_pkg::dp_stat_t                stat
);

	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W = $clog2(TASK_SLOTS + 1);
	localparam int PAR_W = 2 * TIME_BITS + 1;
	localparam int FB = its_pkg::FIELD_BITS;

	logic                  in_fire;
	logic                  full;
	logic                  reg_wr;
	logic                  rd_en;
	logic                  fire;
	logic                  stall;
	logic                  fire_go;
	logic                  out_free;
	logic                  out_load;

	logic [CNT_W-1:0]      used_q;
	logic [CNT_W-1:0]      issue_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [TIME_BITS-1:0]  ival_q;
	logic [TIME_BITS-1:0]  deb_q;
	logic                  disp_q;

	logic [PAR_W-1:0]      par_wdata;
	logic [PAR_W-1:0]      par_rdata;
	logic [SLOT_W-1:0]     lf_waddr;
	logic [TIME_BITS-1:0]  lf_wdata;
	logic [TIME_BITS-1:0]  lf_rdata;

	logic                  v_s1;
	logic [SLOT_W-1:0]     idx_s1;
	logic                  v_s2;
	logic [SLOT_W-1:0]     idx_s2;
	logic [TIME_BITS-1:0]  since_s2;
	logic [TIME_BITS-1:0]  ival_s2;
	logic [TIME_BITS-1:0]  deb_s2;
	logic                  disp_s2;

	logic                  pend_q;
	logic [SLOT_W-1:0]     pend_idx_q;
	logic                  pend_disp_q;

	logic                  out_valid_q;
	its_pkg::status_t      out_status_q;
	logic [its_pkg::INDEX_W-1:0] out_idx_q;
	logic                  out_disp_q;
	logic                  out_last_q;

	its_pkg::status_t      out_status_d;
	logic [SLOT_W-1:0]     out_slot_d;
	logic                  out_disp_d;
	logic                  out_last_d;

	assign s_tready = cmd.idle;
	assign in_fire = s_tvalid && cmd.idle;
	assign full = (used_q == CNT_W'(TASK_SLOTS));
	assign reg_wr = cmd.reg_do && !full;
	assign out_free = !out_valid_q || m_tready;

	assign fire = v_s2 && (since_s2 >= ival_s2) && (since_s2 >= deb_s2);
	assign stall = fire && pend_q && !out_free;
	assign fire_go = fire && !stall;
	assign rd_en = cmd.walk_en && !stall && (issue_q != used_q);

	assign stat.in_fire = in_fire;
	assign stat.in_kind = its_pkg::kind_t'(s_tuser);
	assign stat.out_free = out_free;
	assign stat.walk_done = (issue_q == used_q) && !v_s1 && !v_s2;
	assign stat.pend_valid = pend_q;

	assign par_wdata = {disp_q, deb_q, ival_q};
	assign lf_waddr = reg_wr ? used_q[SLOT_W-1:0] : idx_s2;
	assign lf_wdata = reg_wr ? '0 : now_q;

	its_ram #(
		.WIDTH (PAR_W),
		.DEPTH (TASK_SLOTS)
	) u_par_ram (
		.clk   (clk),
		.we    (reg_wr),
		.waddr (used_q[SLOT_W-1:0]),
		.wdata (par_wdata),
		.re    (rd_en),
		.raddr (issue_q[SLOT_W-1:0]),
		.rdata (par_rdata)
	);

	its_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (TASK_SLOTS)
	) u_lf_ram (
		.clk   (clk),
		.we    (reg_wr || fire_go),
		.waddr (lf_waddr),
		.wdata (lf_wdata),
		.re    (rd_en),
		.raddr (issue_q[SLOT_W-1:0]),
		.rdata (lf_rdata)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q <= TIME_BITS'(s_tdata[FB-1:0]);
			ival_q <= TIME_BITS'(s_tdata[2*FB-1:FB]);
			deb_q <= TIME_BITS'(s_tdata[3*FB-1:2*FB]);
			disp_q <= s_tdata[3*FB];
		end
		if (!stall) begin
			idx_s1 <= issue_q[SLOT_W-1:0];
			idx_s2 <= idx_s1;
			since_s2 <= now_q - lf_rdata;
			ival_s2 <= par_rdata[TIME_BITS-1:0];
			deb_s2 <= par_rdata[2*TIME_BITS-1:TIME_BITS];
			disp_s2 <= par_rdata[2*TIME_BITS];
		end
		if (fire_go) begin
			pend_idx_q <= idx_s2;
			pend_disp_q <= disp_s2;
		end
		if (out_load) begin
			out_status_q <= out_status_d;
			out_idx_q <= its_pkg::INDEX_W'(out_slot_d);
			out_disp_q <= out_disp_d;
			out_last_q <= out_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			issue_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				used_q <= '0;
			end else if (reg_wr) begin
				used_q <= used_q + 1'b1;
			end
			if (cmd.walk_start) begin
				issue_q <= '0;
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
			end else if (!stall) begin
				if (rd_en) begin
					issue_q <= issue_q + 1'b1;
				end
				v_s1 <= rd_en;
				v_s2 <= v_s1;
			end
			if (cmd.walk_start || cmd.flush) begin
				pend_q <= 1'b0;
			end else if (fire_go) begin
				pend_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		out_load = 1'b0;
		out_status_d = its_pkg::ST_FIRED;
		out_slot_d = pend_idx_q;
		out_disp_d = pend_disp_q;
		out_last_d = 1'b0;
		if (cmd.reg_do) begin
			out_load = 1'b1;
			out_disp_d = 1'b0;
			out_last_d = 1'b1;
			if (full) begin
				out_status_d = its_pkg::ST_FULL;
				out_slot_d = '0;
			end else begin
				out_status_d = its_pkg::ST_REGISTERED;
				out_slot_d = used_q[SLOT_W-1:0];
			end
		end else if (cmd.flush) begin
			out_load = 1'b1;
			out_last_d = 1'b1;
		end else if (fire_go && pend_q) begin
			out_load = 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {2'b00, out_disp_q, out_idx_q};
	assign m_tuser = out_status_q;
	assign m_tlast = out_last_q;

endmodule
